// File: hdl/tks_pkg.sv
// tks_pkg: shared widths, codes and controller/datapath interface types
// for the table key search block
// no dependencies
package tks_pkg;

   // field widths
   localparam int COUNT_W = 11;
   localparam int POS_W   = 10;
   localparam int DATA_W  = 32;
   // signed working index, holds -1 and sums of two counts
   localparam int INDEX_W = COUNT_W + 2;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   // register map, indexed by paddr[2]
   localparam logic REG_ENTRY_COUNT = 1'b0;
   localparam logic REG_SEARCH_MODE = 1'b1;

   // item kinds
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // search methods
   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic wr_en;     // write the load beat into the table
      logic start;     // set up range and counters for a search beat
      logic rd_en;     // read the entry at the current midpoint
      logic compare;   // compare read entry with key, update range
      logic load_rsp;  // move the result into the output register
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic range_empty;
      logic hit;
   } dp_status_type;

endpackage

// File: hdl/tks_ram.sv
// tks_ram: generic single-port RAM with registered read
// no dependencies
module tks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/tks_ctrl.sv
// tks_ctrl: sequencer for table loads and searches
// depends on tks_pkg
module tks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tks_pkg::dp_status_type status,
   output tks_pkg::dp_cmd_type    cmd
);
   import tks_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_CMP    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_SEARCH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_READ: begin
            if (status.range_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = status.hit ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat valid flag
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a compare always follows the read of its entry
   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ($past(state_ff) == ST_READ))
      else $error("compare without preceding table read");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while stalled");

   a_rsp_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

   // table writes only happen outside a search
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (state_ff == ST_IDLE))
      else $error("table write during search");

endmodule

// File: hdl/tks_dpath.sv
// tks_dpath: search range registers, comparator, counters and result register
// depends on tks_pkg and tks_ram
module tks_dpath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tks_pkg::dp_cmd_type         cmd,
   output tks_pkg::dp_status_type      status,
   input  logic [tks_pkg::COUNT_W-1:0] entry_count,
   input  logic                        search_mode,
   input  logic [tks_pkg::POS_W-1:0]   req_position,
   input  logic [tks_pkg::DATA_W-1:0]  req_value,
   output logic                        rsp_found,
   output logic [tks_pkg::POS_W-1:0]   rsp_match_index,
   output logic [tks_pkg::COUNT_W-1:0] rsp_comparison_count
);
   import tks_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic signed [INDEX_W-1:0] low_ff, low_in;
   logic signed [INDEX_W-1:0] hi_ff, hi_in;
   logic signed [INDEX_W-1:0] mid_ff, mid_next;
   logic signed [INDEX_W:0]   mid_sum;
   logic signed [DATA_W-1:0]  key_ff;
   logic [COUNT_W-1:0]        cmp_ff;
   logic                      found_ff;
   logic [POS_W-1:0]          idx_ff;
   logic [COUNT_W-1:0]        live_count;
   logic [ADDR_W-1:0]         ram_addr;
   logic [DATA_W-1:0]         ram_rdata;
   logic                      ram_we;
   logic                      pos_ok;
   logic                      key_less;

   logic                      out_found_ff;
   logic [POS_W-1:0]          out_idx_ff;
   logic [COUNT_W-1:0]        out_cmp_ff;

   // entry count clipped to the table depth
   assign live_count = (32'(entry_count) > TABLE_DEPTH) ?
                       COUNT_W'(TABLE_DEPTH) : entry_count;

   // midpoint: low itself for a scan, floor of the average for halving
   assign mid_sum  = {low_ff[INDEX_W-1], low_ff} + {hi_ff[INDEX_W-1], hi_ff};
   assign mid_next = (search_mode == MODE_BINARY) ? mid_sum[INDEX_W:1] : low_ff;

   // table port: loads write, searches read at the midpoint
   assign pos_ok   = (32'(req_position) < TABLE_DEPTH);
   assign ram_we   = cmd.wr_en && pos_ok;
   assign ram_addr = cmd.wr_en ? ADDR_W'(req_position) : ADDR_W'(mid_next);

   tks_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_value),
      .rdata (ram_rdata)
   );

   // comparator status
   assign status.hit         = ($signed(ram_rdata) == key_ff);
   assign status.range_empty = (low_ff > hi_ff);
   assign key_less           = (key_ff < $signed(ram_rdata));

   // range setup on a search start, range update after a miss
   always_comb begin
      low_in = low_ff;
      hi_in  = hi_ff;
      if (cmd.start) begin
         low_in = '0;
         hi_in  = $signed({{(INDEX_W-COUNT_W){1'b0}}, live_count}) -
                  $signed(INDEX_W'(1));
      end else if (cmd.compare && !status.hit) begin
         if ((search_mode == MODE_BINARY) && key_less) begin
            hi_in = mid_ff - $signed(INDEX_W'(1));
         end else begin
            low_in = mid_ff + $signed(INDEX_W'(1));
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      low_ff <= low_in;
      hi_ff  <= hi_in;
      if (cmd.rd_en) begin
         mid_ff <= mid_next;
      end
      if (cmd.start) begin
         key_ff   <= $signed(req_value);
         cmp_ff   <= '0;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (cmd.compare) begin
         cmp_ff <= cmp_ff + COUNT_W'(1);
         if (status.hit) begin
            found_ff <= 1'b1;
            idx_ff   <= POS_W'(mid_ff);
         end
      end
   end

   // output register, held while the result beat stalls
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_found_ff <= found_ff;
         out_idx_ff   <= idx_ff;
         out_cmp_ff   <= cmp_ff;
      end
   end

   assign rsp_found            = out_found_ff;
   assign rsp_match_index      = out_idx_ff;
   assign rsp_comparison_count = out_cmp_ff;

   // every compare counts exactly once
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.compare && !cmd.start) |=> (cmp_ff == COUNT_W'($past(cmp_ff) + 1'b1)))
      else $error("comparison count did not advance");

endmodule

// File: hdl/table_key_search.sv
// table_key_search: searchable table of signed 32-bit entries
// request beats carry a kind in req_tuser: load writes one entry, search
// looks for a key. each search gives one result beat, a load gives none.
// csr port: entry_count at byte address 0, search_mode at byte address 4
// (0 linear scan from index 0, 1 halving search over an ascending table).
// sequence: a load writes its entry when taken and leaves the block idle. a
// search ends on a match or when the range runs out. each comparison is one
// read of the single table port followed by one compare step. halving needs
// at most floor(log2(entry_count)) + 1 comparisons, a scan up to entry_count
// comparisons, entry_count being clipped to the table depth.
// a finished result sits in an output register; the next request beat is
// taken while it waits. if rsp_tready stays low, a following search holds
// at its end until the result register frees up, and req_tready is low.
// reset clears entry_count, search_mode and the handshake state; table
// contents are undefined until loaded and must be written before searched.
// depends on tks_pkg, tks_ctrl, tks_dpath and tks_ram
module table_key_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // request beat
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] position, [41:10] value, [47:42] zero
   input  logic [tks_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] func
   input  logic                            req_tuser,
   // result beat
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] match_index, [20:10] comparison_count, [23:21] zero
   output logic [tks_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] found
   output logic                            rsp_tuser,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import tks_pkg::*;

   logic [COUNT_W-1:0] entry_count_ff;
   logic               search_mode_ff;
   logic               csr_write;
   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               found;
   logic [POS_W-1:0]   match_index;
   logic [COUNT_W-1:0] comparison_count;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         search_mode_ff <= MODE_LINEAR;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_ENTRY_COUNT) begin
            entry_count_ff <= csr_pwdata[COUNT_W-1:0];
         end else begin
            search_mode_ff <= csr_pwdata[0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SEARCH_MODE) ?
                       {31'b0, search_mode_ff} :
                       {{(32-COUNT_W){1'b0}}, entry_count_ff};

   tks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tks_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .entry_count          (entry_count_ff),
      .search_mode          (search_mode_ff),
      .req_position         (req_tdata[POS_W-1:0]),
      .req_value            (req_tdata[POS_W+DATA_W-1:POS_W]),
      .rsp_found            (found),
      .rsp_match_index      (match_index),
      .rsp_comparison_count (comparison_count)
   );

   // result beat packing
   assign rsp_tdata = {{(RSP_TDATA_W-POS_W-COUNT_W){1'b0}}, comparison_count, match_index};
   assign rsp_tuser = found;

endmodule

// File: verif/table_key_search_tb.sv
// table_key_search_tb: self-checking bench for the table key search block
// drives load and search beats, mirrors the table to predict each search result
// depends on tks_pkg and table_key_search
`timescale 1ns / 1ps

module table_key_search_tb;
   import tks_pkg::*;

   localparam int DEPTH = 1024;
   localparam logic [2:0] ADDR_COUNT = {REG_ENTRY_COUNT, 2'b00};
   localparam logic [2:0] ADDR_MODE  = {REG_SEARCH_MODE, 2'b00};
   localparam int PAD_W = REQ_TDATA_W - POS_W - DATA_W;

   typedef struct packed {
      logic                     func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_beat_type;

   typedef struct packed {
      logic                found;
      logic [POS_W-1:0]    match_index;
      logic [COUNT_W-1:0]  compare_count;
   } search_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [9:0] position, [41:10] value, [47:42] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] func
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [9:0] match_index, [20:10] comparison_count, [23:21] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [0] found
   logic rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // stimulus side: beats waiting to be driven and the generator's view of the table
   req_beat_type req_beats_todo[$];
   logic signed [DATA_W-1:0] gen_image [DEPTH];
   bit gen_written [DEPTH];

   // checking side: table mirror, register copies, results still owed
   logic signed [DATA_W-1:0] entry_mirror [DEPTH];
   logic [COUNT_W-1:0] shadow_count = '0;
   logic shadow_mode = MODE_LINEAR;
   search_result_type lookup_results_due[$];
   int beats_in = 0;
   int results_checked = 0;
   int mismatch_count = 0;

   table_key_search #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void note_mismatch(input string what);
      if (mismatch_count < 10) $display("MISMATCH: %s", what);
      mismatch_count++;
   endfunction

   // expected outcome of a search against the mirrored table and registers
   function automatic search_result_type predict_lookup(input logic signed [DATA_W-1:0] key);
      search_result_type r;
      int n, lo, hi, mid, cmp, i;
      bit hit;
      r = '0;
      cmp = 0;
      hit = 1'b0;
      n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
      if (shadow_mode == MODE_BINARY) begin
         lo = 0;
         hi = n - 1;
         while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            cmp++;
            if (key == entry_mirror[mid]) begin
               hit = 1'b1;
               r.match_index = mid[POS_W-1:0];
            end else if (key < entry_mirror[mid]) begin
               hi = mid - 1;
            end else begin
               lo = mid + 1;
            end
         end
      end else begin
         for (i = 0; i < n && !hit; i++) begin
            cmp++;
            if (entry_mirror[i] == key) begin
               hit = 1'b1;
               r.match_index = i[POS_W-1:0];
            end
         end
      end
      r.found = hit;
      r.compare_count = cmp[COUNT_W-1:0];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      req_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_beats_todo.size() != 0 &&
             $urandom_range(99) >= ((beats_in < 450) ? 32 : (beats_in < 900) ? 88 : 0)) begin
            beat = req_beats_todo.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {{PAD_W{1'b0}}, beat.value, beat.position};
            req_tuser <= beat.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= ((beats_in < 450) ? 88 : (beats_in < 900) ? 32 : 0);
      end
   end

   // monitor: register writes, request beats into the predictor, result beats checked
   always @(posedge clock) begin
      search_result_type due;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_ENTRY_COUNT) shadow_count = csr_pwdata[COUNT_W-1:0];
            else shadow_mode = csr_pwdata[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (lookup_results_due.size() == 0) begin
               note_mismatch($sformatf("result beat with no search outstanding: tdata %h tuser %b",
                                       rsp_tdata, rsp_tuser));
            end else begin
               due = lookup_results_due.pop_front();
               if (rsp_tuser !== due.found || rsp_tdata[9:0] !== due.match_index ||
                   rsp_tdata[20:10] !== due.compare_count) begin
                  note_mismatch($sformatf(
                     "search %0d: found exp %b got %b, index exp %0d got %0d, compares exp %0d got %0d",
                     results_checked, due.found, rsp_tuser, due.match_index, rsp_tdata[9:0],
                     due.compare_count, rsp_tdata[20:10]));
               end
            end
            results_checked <= results_checked + 1;
         end
         if (req_tvalid && req_tready) begin
            beats_in <= beats_in + 1;
            if (req_tuser == FUNC_LOAD) entry_mirror[req_tdata[9:0]] = req_tdata[41:10];
            else lookup_results_due.push_back(predict_lookup(req_tdata[41:10]));
         end
      end
   end

   function automatic void queue_load(input int pos, input logic signed [DATA_W-1:0] val);
      req_beat_type b;
      b.func = FUNC_LOAD;
      b.position = pos[POS_W-1:0];
      b.value = val;
      req_beats_todo.push_back(b);
      gen_image[pos] = val;
      gen_written[pos] = 1'b1;
   endfunction

   function automatic void queue_search(input logic signed [DATA_W-1:0] key);
      req_beat_type b;
      b.func = FUNC_SEARCH;
      b.position = POS_W'($urandom_range(0, DEPTH - 1));
      b.value = key;
      req_beats_todo.push_back(b);
   endfunction

   // wait until every beat is sent and every result is back, then let a load settle
   task automatic wait_drained();
      do @(negedge clock);
      while (req_beats_todo.size() != 0 || req_tvalid || lookup_results_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // register write followed by a readback
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data,
                            input logic [31:0] mask);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (data & mask)) begin
         note_mismatch($sformatf("readback at %0d: exp %h got %h", addr, data & mask, csr_prdata));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // one setting of the registers, then random loads and searches under it
   task automatic run_phase(input int count, input logic mode, input int n_items,
                            input bit keep_order, input bit narrow);
      int live, pos, nb, k, r;
      logic signed [DATA_W-1:0] val;
      wait_drained();
      write_reg(ADDR_COUNT, count, 32'h7FF);
      write_reg(ADDR_MODE, {31'b0, mode}, 32'h1);
      live = (count > DEPTH) ? DEPTH : count;
      // every entry in the searched range is written before any search
      for (int i = 0; i < live; i++) begin
         if (!gen_written[i]) queue_load(i, narrow ? $urandom_range(0, 8) - 4 : $urandom);
      end
      for (k = 0; k < n_items; k++) begin
         r = $urandom_range(99);
         if (r < 60) begin
            r = $urandom_range(99);
            if (live != 0 && r < 70) val = gen_image[$urandom_range(0, live - 1)];
            else if (live != 0 && r < 85)
               val = gen_image[$urandom_range(0, live - 1)] + ($urandom_range(1) ? 1 : -1);
            else val = narrow ? $urandom_range(0, 8) - 4 : $urandom;
            queue_search(val);
         end else begin
            pos = (live != 0 && $urandom_range(99) < 80) ? $urandom_range(0, live - 1)
                                                          : $urandom_range(0, DEPTH - 1);
            if (keep_order) begin
               // copying a neighbor keeps the table non-descending
               nb = $urandom_range(1) ? pos - 1 : pos + 1;
               if (nb < 0) nb = 0;
               if (nb >= DEPTH) nb = DEPTH - 1;
               val = gen_image[nb];
            end else begin
               val = narrow ? $urandom_range(0, 8) - 4 : $urandom;
            end
            queue_load(pos, val);
         end
      end
   endtask

   // ascending contents over the whole table, so any prefix suits a halving search
   function automatic void queue_ascending_fill();
      longint acc;
      acc = -64'sd2147483648 + $urandom_range(0, 1 << 20);
      for (int i = 0; i < DEPTH; i++) begin
         queue_load(i, acc[DATA_W-1:0]);
         acc += $urandom_range(1, 1 << 22);
      end
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty range after reset, then extreme values and the top position
      queue_search(32'sh80000000);
      queue_search(32'sh0);
      queue_load(0, 32'sh80000000);
      queue_load(1, -32'sd1);
      queue_load(2, 32'sh0);
      queue_load(3, 32'sh7FFFFFFF);
      queue_load(DEPTH - 1, 32'sh5A5A5A5A);
      run_phase(4, MODE_LINEAR, 0, 1'b0, 1'b0);
      queue_search(32'sh80000000);
      queue_search(-32'sd1);
      queue_search(32'sh0);
      queue_search(32'sh7FFFFFFF);
      queue_search(32'sd7);
      run_phase(4, MODE_BINARY, 0, 1'b0, 1'b0);
      queue_search(32'sh80000000);
      queue_search(32'sh7FFFFFFF);
      queue_search(32'sh0);
      queue_search(32'sd7);
      queue_search(-32'sd5);
      run_phase(1, MODE_BINARY, 0, 1'b0, 1'b0);
      queue_search(32'sh80000000);
      queue_search(32'sd1);

      // small tables with repeated values, then halving over an unsorted table
      run_phase(16, MODE_LINEAR, 40, 1'b0, 1'b1);
      run_phase(16, MODE_BINARY, 20, 1'b0, 1'b1);
      queue_ascending_fill();
      // count above the table depth clamps to the full table
      run_phase(2047, MODE_BINARY, 30, 1'b1, 1'b0);
      queue_search(32'sh80000000);
      queue_search(32'sh7FFFFFFF);
      run_phase(1024, MODE_LINEAR, 6, 1'b1, 1'b0);
      queue_search(32'sh7FFFFFFF);
      run_phase(1000, MODE_BINARY, 30, 1'b1, 1'b0);
      run_phase(40, MODE_LINEAR, 30, 1'b0, 1'b0);
      run_phase(0, MODE_BINARY, 4, 1'b0, 1'b0);
      run_phase(2, MODE_BINARY, 20, 1'b0, 1'b1);

      wait_drained();
      repeat (40) @(posedge clock);
      $display("covered %0d request beats and %0d search results, %0d mismatches",
               beats_in, results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("table_key_search_tb passed");
      end else begin
         $display("table_key_search_tb failed");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("table_key_search_tb failed");
      $finish;
   end

endmodule
